[design/cbf_pkg.sv]
// ----------------------------------------------------------------------------
// Cubic Bezier flattener package
// Shared widths, defaults, sequencer states and operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cbf_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int COORD_W          = 16;
  localparam int COUNT_W          = 7;
  localparam int LWIDTH_W         = 16;
  localparam int COLOR_W          = 24;
  localparam int MUL_B_W          = COORD_W + 1;
  localparam int QUO_BITS         = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WB,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  // The order matters: the sequencer steps through these codes one by one.
  typedef enum logic [4:0] {
    OP_NN,
    OP_DEN,
    OP_A2,
    OP_A3,
    OP_B2,
    OP_B3,
    OP_A2B,
    OP_AB2,
    OP_X0,
    OP_X1,
    OP_X2,
    OP_X3,
    OP_Y0,
    OP_Y1,
    OP_Y2,
    OP_Y3
  } op_t;

endpackage

`default_nettype wire

[design/cbf_mul.sv]
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned weight times signed coordinate, product registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cbf_mul import cbf_pkg::*; #(
  parameter int A_W = 21
) (
  input  wire logic                         clk,
  input  wire logic [A_W-1:0]               op_a,
  input  wire logic signed [MUL_B_W-1:0]    op_b,
  output logic signed [A_W+MUL_B_W:0]       prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= $signed({1'b0, op_a}) * op_b;
  end

endmodule

`default_nettype wire

[design/cbf_div.sv]
// ----------------------------------------------------------------------------
// Iterative divider
// Signed numerator by unsigned denominator, one quotient bit per cycle,
// truncation towards zero and saturation to a 16-bit signed quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module cbf_div import cbf_pkg::*; #(
  parameter int ACC_W = 38,
  parameter int DEN_W = 21
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic signed [ACC_W-1:0]    num,
  input  wire logic [DEN_W-1:0]           den,
  output logic                            done,
  output logic signed [COORD_W-1:0]       quo
);

  localparam int CNT_W = $clog2(QUO_BITS + 1);
  localparam logic [QUO_BITS-1:0] POS_MAX = {1'b0, {(QUO_BITS-1){1'b1}}};
  localparam logic [QUO_BITS-1:0] NEG_MAX = {1'b1, {(QUO_BITS-1){1'b0}}};

  logic [ACC_W-1:0]    rem_r;
  logic [ACC_W-1:0]    dsh_r;
  logic [QUO_BITS-1:0] q_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                neg_r;
  logic                active_r;
  logic                fits;

  assign fits = (rem_r >= dsh_r);
  assign done = active_r && (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (start) begin
      active_r <= 1'b1;
      cnt_r    <= CNT_W'(QUO_BITS);
    end else if (done) begin
      active_r <= 1'b0;
    end else if (active_r) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[ACC_W-1];
      rem_r <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
      dsh_r <= ACC_W'({den, {(QUO_BITS-1){1'b0}}});
      q_r   <= '0;
    end else if (active_r && (cnt_r != '0)) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[QUO_BITS-2:0], fits};
      dsh_r <= dsh_r >> 1;
    end
  end

  always_comb begin
    if (neg_r) begin
      quo = (q_r > NEG_MAX) ? $signed(NEG_MAX) : $signed(QUO_BITS'(-q_r));
    end else begin
      quo = (q_r > POS_MAX) ? $signed(POS_MAX) : $signed(q_r);
    end
  end

endmodule

`default_nettype wire

[design/cubic_bezier_flattener_core.sv]
// ----------------------------------------------------------------------------
// Cubic Bezier flattener core
// Uniform subdivision of a cubic curve into n line segments, evaluated
// exactly with one shared multiplier and an iterative divider.
// Per segment, the shared multiplier forms the four Bernstein weights, then
// the x sum, which the 16-step divider divides by n^3, then the y sum the
// same way; the segment word follows. busy stays high for the whole curve,
// and a new curve is taken only while the sequencer is idle.
// The receiver cannot stall; every word is strobed for one cycle.
// Reset is synchronous and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_flattener_core import cbf_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic signed [COORD_W-1:0]  in_c0_x,
  input  wire logic signed [COORD_W-1:0]  in_c0_y,
  input  wire logic signed [COORD_W-1:0]  in_c1_x,
  input  wire logic signed [COORD_W-1:0]  in_c1_y,
  input  wire logic signed [COORD_W-1:0]  in_c2_x,
  input  wire logic signed [COORD_W-1:0]  in_c2_y,
  input  wire logic signed [COORD_W-1:0]  in_c3_x,
  input  wire logic signed [COORD_W-1:0]  in_c3_y,
  input  wire logic [COUNT_W-1:0]         in_segment_count,
  input  wire logic [LWIDTH_W-1:0]        in_line_width,
  input  wire logic [COLOR_W-1:0]         in_rgb_color,
  output logic                            out_valid,
  output logic signed [COORD_W-1:0]       out_from_x,
  output logic signed [COORD_W-1:0]       out_from_y,
  output logic signed [COORD_W-1:0]       out_to_x,
  output logic signed [COORD_W-1:0]       out_to_y,
  output logic [LWIDTH_W-1:0]             out_width_out,
  output logic [COLOR_W-1:0]              out_color_out,
  output logic                            out_last_segment
);

  localparam int NW    = $clog2(MAX_SEGMENTS + 1);
  localparam int WW    = 3 * NW;
  localparam int ACC_W = WW + COORD_W + 1;
  localparam int PW    = WW + MUL_B_W + 1;
  localparam int CNT_W = (NW > COUNT_W) ? NW : COUNT_W;

  state_t state_r, state_nxt;
  op_t    op_r;

  logic [NW-1:0]               n_r, i_r, a_val;
  logic [CNT_W-1:0]            cnt_ext;
  logic [NW-1:0]               n_clamp;
  logic signed [COORD_W-1:0]   c0x_r, c0y_r, c1x_r, c1y_r, c2x_r, c2y_r, c3x_r, c3y_r;
  logic [LWIDTH_W-1:0]         width_r;
  logic [COLOR_W-1:0]          color_r;
  logic [WW-1:0]               den_r, wa2_r, wb2_r, w0_r, w1_r, w2_r, w3_r;
  logic signed [ACC_W-1:0]     acc_r;
  logic signed [COORD_W-1:0]   px_r, py_r, nx_r, ny_r;

  logic [WW-1:0]               mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PW-1:0]        mul_p;
  logic [WW-1:0]               prod_w, prod_w3;
  logic signed [ACC_W-1:0]     prod_acc;

  logic                        div_start, div_done;
  logic signed [COORD_W-1:0]   div_q;
  logic                        accept, emit, coord_done;

  cbf_mul #(.A_W(WW)) u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_p)
  );

  cbf_div #(.ACC_W(ACC_W), .DEN_W(WW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_q)
  );

  assign cnt_ext = CNT_W'(in_segment_count);
  always_comb begin
    if (cnt_ext == '0) begin
      n_clamp = NW'(1);
    end else if (cnt_ext > CNT_W'(MAX_SEGMENTS)) begin
      n_clamp = NW'(MAX_SEGMENTS);
    end else begin
      n_clamp = cnt_ext[NW-1:0];
    end
  end

  assign a_val    = n_r - i_r;
  assign prod_w   = mul_p[WW-1:0];
  assign prod_w3  = prod_w + {prod_w[WW-2:0], 1'b0};
  assign prod_acc = mul_p[ACC_W-1:0];
  assign coord_done = (op_r == OP_X3) || (op_r == OP_Y3);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (start) state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_WB;
      ST_WB:       state_nxt = coord_done ? ST_DIV_GO : ST_MUL;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_nxt = (op_r == OP_X3) ? ST_MUL : ST_EMIT;
      ST_EMIT:     state_nxt = (i_r == n_r) ? ST_IDLE : ST_MUL;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != ST_IDLE);
    accept    = (state_r == ST_IDLE) && start;
    div_start = (state_r == ST_DIV_GO);
    emit      = (state_r == ST_EMIT);
  end

  always_comb begin
    case (op_r)
      OP_NN:   begin mul_a = WW'(n_r);   mul_b = MUL_B_W'(n_r);   end
      OP_DEN:  begin mul_a = den_r;      mul_b = MUL_B_W'(n_r);   end
      OP_A2:   begin mul_a = WW'(a_val); mul_b = MUL_B_W'(a_val); end
      OP_A3:   begin mul_a = wa2_r;      mul_b = MUL_B_W'(a_val); end
      OP_B2:   begin mul_a = WW'(i_r);   mul_b = MUL_B_W'(i_r);   end
      OP_B3:   begin mul_a = wb2_r;      mul_b = MUL_B_W'(i_r);   end
      OP_A2B:  begin mul_a = wa2_r;      mul_b = MUL_B_W'(i_r);   end
      OP_AB2:  begin mul_a = wb2_r;      mul_b = MUL_B_W'(a_val); end
      OP_X0:   begin mul_a = w0_r;       mul_b = MUL_B_W'(c0x_r); end
      OP_X1:   begin mul_a = w1_r;       mul_b = MUL_B_W'(c1x_r); end
      OP_X2:   begin mul_a = w2_r;       mul_b = MUL_B_W'(c2x_r); end
      OP_X3:   begin mul_a = w3_r;       mul_b = MUL_B_W'(c3x_r); end
      OP_Y0:   begin mul_a = w0_r;       mul_b = MUL_B_W'(c0y_r); end
      OP_Y1:   begin mul_a = w1_r;       mul_b = MUL_B_W'(c1y_r); end
      OP_Y2:   begin mul_a = w2_r;       mul_b = MUL_B_W'(c2y_r); end
      OP_Y3:   begin mul_a = w3_r;       mul_b = MUL_B_W'(c3y_r); end
      default: begin mul_a = '0;         mul_b = '0;              end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c0x_r   <= in_c0_x;
      c0y_r   <= in_c0_y;
      c1x_r   <= in_c1_x;
      c1y_r   <= in_c1_y;
      c2x_r   <= in_c2_x;
      c2y_r   <= in_c2_y;
      c3x_r   <= in_c3_x;
      c3y_r   <= in_c3_y;
      width_r <= in_line_width;
      color_r <= in_rgb_color;
      n_r     <= n_clamp;
      i_r     <= NW'(1);
      px_r    <= in_c0_x;
      py_r    <= in_c0_y;
      op_r    <= OP_NN;
    end
    if (state_r == ST_WB) begin
      case (op_r)
        OP_NN, OP_DEN: den_r <= prod_w;
        OP_A2:         wa2_r <= prod_w;
        OP_A3:         w0_r  <= prod_w;
        OP_B2:         wb2_r <= prod_w;
        OP_B3:         w3_r  <= prod_w;
        OP_A2B:        w1_r  <= prod_w3;
        OP_AB2:        w2_r  <= prod_w3;
        OP_X0, OP_Y0:  acc_r <= prod_acc;
        default:       acc_r <= acc_r + prod_acc;
      endcase
      if (!coord_done) begin
        op_r <= op_t'(op_r + 5'd1);
      end
    end
    if ((state_r == ST_DIV_WAIT) && div_done) begin
      if (op_r == OP_X3) begin
        nx_r <= div_q;
        op_r <= OP_Y0;
      end else begin
        ny_r <= div_q;
      end
    end
    if (emit) begin
      out_from_x       <= px_r;
      out_from_y       <= py_r;
      out_to_x         <= nx_r;
      out_to_y         <= ny_r;
      out_width_out    <= width_r;
      out_color_out    <= color_r;
      out_last_segment <= (i_r == n_r);
      px_r             <= nx_r;
      py_r             <= ny_r;
      i_r              <= i_r + 1'b1;
      op_r             <= OP_A2;
    end
  end

endmodule

`default_nettype wire

[verif/tb_cubic_bezier_flattener_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cubic Bezier flattener core testbench
// Sends curves through the start/busy command port and checks every strobed
// segment word against an exact integer model of the uniform subdivision.
// A short table of directed curves covers the extreme coordinates, zero and
// saturated segment counts and truncation of negative points. Random curves
// follow, mostly with few segments, under random idle gaps.
// ----------------------------------------------------------------------------

module tb_cubic_bezier_flattener_core import cbf_pkg::*;;

  localparam int MAX_SEG     = MAX_SEGMENTS_DEF;
  localparam int DIR_ROWS    = 16;
  localparam int RAND_CURVES = 260;
  localparam int CYCLE_LIMIT = 8_000_000;

  typedef struct {
    logic signed [COORD_W-1:0] c0_x;
    logic signed [COORD_W-1:0] c0_y;
    logic signed [COORD_W-1:0] c1_x;
    logic signed [COORD_W-1:0] c1_y;
    logic signed [COORD_W-1:0] c2_x;
    logic signed [COORD_W-1:0] c2_y;
    logic signed [COORD_W-1:0] c3_x;
    logic signed [COORD_W-1:0] c3_y;
    logic [COUNT_W-1:0]        seg_count;
    logic [LWIDTH_W-1:0]       lwidth;
    logic [COLOR_W-1:0]        color;
  } curve_t;

  typedef struct {
    logic signed [COORD_W-1:0] from_x;
    logic signed [COORD_W-1:0] from_y;
    logic signed [COORD_W-1:0] to_x;
    logic signed [COORD_W-1:0] to_y;
    logic [LWIDTH_W-1:0]       lwidth;
    logic [COLOR_W-1:0]        color;
    logic                      is_last;
  } seg_t;

  typedef struct {
    curve_t curve;
    bit     typed;
    seg_t   want;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] in_c0_x = '0;
  logic signed [COORD_W-1:0] in_c0_y = '0;
  logic signed [COORD_W-1:0] in_c1_x = '0;
  logic signed [COORD_W-1:0] in_c1_y = '0;
  logic signed [COORD_W-1:0] in_c2_x = '0;
  logic signed [COORD_W-1:0] in_c2_y = '0;
  logic signed [COORD_W-1:0] in_c3_x = '0;
  logic signed [COORD_W-1:0] in_c3_y = '0;
  logic [COUNT_W-1:0]        in_segment_count = '0;
  logic [LWIDTH_W-1:0]       in_line_width = '0;
  logic [COLOR_W-1:0]        in_rgb_color = '0;
  logic                      out_valid;
  logic signed [COORD_W-1:0] out_from_x;
  logic signed [COORD_W-1:0] out_from_y;
  logic signed [COORD_W-1:0] out_to_x;
  logic signed [COORD_W-1:0] out_to_y;
  logic [LWIDTH_W-1:0]       out_width_out;
  logic [COLOR_W-1:0]        out_color_out;
  logic                      out_last_segment;

  seg_t     pending_segments [$];
  seg_t     got_seg;
  dir_row_t dir_table [DIR_ROWS];
  int       mismatch_count = 0;
  int       cycle_count = 0;

  cubic_bezier_flattener_core #(
    .MAX_SEGMENTS(MAX_SEG)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_c0_x         (in_c0_x),
    .in_c0_y         (in_c0_y),
    .in_c1_x         (in_c1_x),
    .in_c1_y         (in_c1_y),
    .in_c2_x         (in_c2_x),
    .in_c2_y         (in_c2_y),
    .in_c3_x         (in_c3_x),
    .in_c3_y         (in_c3_y),
    .in_segment_count(in_segment_count),
    .in_line_width   (in_line_width),
    .in_rgb_color    (in_rgb_color),
    .out_valid       (out_valid),
    .out_from_x      (out_from_x),
    .out_from_y      (out_from_y),
    .out_to_x        (out_to_x),
    .out_to_y        (out_to_y),
    .out_width_out   (out_width_out),
    .out_color_out   (out_color_out),
    .out_last_segment(out_last_segment)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [COORD_W-1:0] curve_point(
    input longint p0, input longint p1, input longint p2, input longint p3,
    input int step, input int nseg);
    longint a;
    longint b;
    longint num;
    longint den;
    longint q;
    a   = nseg - step;
    b   = step;
    num = a * a * a * p0 + 3 * a * a * b * p1 + 3 * a * b * b * p2 + b * b * b * p3;
    den = longint'(nseg) * nseg * nseg;
    q   = num / den;
    if (q > 32767) begin
      q = 32767;
    end
    if (q < -32768) begin
      q = -32768;
    end
    return COORD_W'(q);
  endfunction

  function automatic void flatten_curve(input curve_t c);
    int                        nseg;
    seg_t                      s;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    if (c.seg_count == '0) begin
      nseg = 1;
    end else if (int'(c.seg_count) > MAX_SEG) begin
      nseg = MAX_SEG;
    end else begin
      nseg = int'(c.seg_count);
    end
    px = c.c0_x;
    py = c.c0_y;
    for (int i = 1; i <= nseg; i++) begin
      s.from_x  = px;
      s.from_y  = py;
      s.to_x    = curve_point(c.c0_x, c.c1_x, c.c2_x, c.c3_x, i, nseg);
      s.to_y    = curve_point(c.c0_y, c.c1_y, c.c2_y, c.c3_y, i, nseg);
      s.lwidth  = c.lwidth;
      s.color   = c.color;
      s.is_last = (i == nseg);
      pending_segments.push_back(s);
      px = s.to_x;
      py = s.to_y;
    end
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      return 16'sh8000;
    end else if (roll == 1) begin
      return 16'sh7FFF;
    end else if (roll == 2) begin
      return COORD_W'(int'($urandom_range(0, 64)) - 32);
    end
    return COORD_W'($urandom);
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want_v,
                             input logic signed [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  task automatic send_curve(input dir_row_t r, input bit no_idle);
    int gap;
    int roll;
    in_c0_x          <= r.curve.c0_x;
    in_c0_y          <= r.curve.c0_y;
    in_c1_x          <= r.curve.c1_x;
    in_c1_y          <= r.curve.c1_y;
    in_c2_x          <= r.curve.c2_x;
    in_c2_y          <= r.curve.c2_y;
    in_c3_x          <= r.curve.c3_x;
    in_c3_y          <= r.curve.c3_y;
    in_segment_count <= r.curve.seg_count;
    in_line_width    <= r.curve.lwidth;
    in_rgb_color     <= r.curve.color;
    if (!start) begin
      start <= 1'b1;
    end
    do @(posedge clk); while (busy);
    if (r.typed) begin
      pending_segments.push_back(r.want);
    end else begin
      flatten_curve(r.curve);
    end
    roll = $urandom_range(0, 19);
    if (no_idle || roll >= 8) begin
      gap = 0;
    end else if (roll == 0) begin
      gap = $urandom_range(200, 1500);
    end else if (roll < 4) begin
      gap = $urandom_range(20, 200);
    end else begin
      gap = $urandom_range(1, 19);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_segments.size() == 0) begin
        $error("unexpected segment word: from (%0d,%0d) to (%0d,%0d)",
               out_from_x, out_from_y, out_to_x, out_to_y);
        mismatch_count++;
      end else begin
        got_seg = pending_segments.pop_front();
        check_field("from_x", got_seg.from_x, out_from_x);
        check_field("from_y", got_seg.from_y, out_from_y);
        check_field("to_x", got_seg.to_x, out_to_x);
        check_field("to_y", got_seg.to_y, out_to_y);
        check_field("width_out", got_seg.lwidth, out_width_out);
        check_field("color_out", got_seg.color, out_color_out);
        check_field("last_segment", got_seg.is_last, out_last_segment);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    dir_row_t r;
    bit       no_idle;

    // A count of zero or one gives a single segment straight from P0 to P3.
    dir_table[0]  = '{'{16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                        16'sh7FFF, 16'sh7FFF, 7'd0, 16'h0000, 24'h000000}, 1'b1,
                      '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'h0000, 24'h000000,
                        1'b1}};
    dir_table[1]  = '{'{16'sh7FFF, 16'sh8000, 16'sh1234, -16'sd4660, 16'sh7FFF, 16'sh8000,
                        16'sh8000, 16'sh7FFF, 7'd1, 16'hFFFF, 24'hFFFFFF}, 1'b1,
                      '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'hFFFF, 24'hFFFFFF,
                        1'b1}};
    dir_table[2]  = '{'{16'sh0005, -16'sd7, 16'sh0100, 16'sh0200, -16'sd300, 16'sh0000,
                        -16'sd9, 16'sh0041, 7'd0, 16'h5555, 24'hAAAAAA}, 1'b1,
                      '{16'sh0005, -16'sd7, -16'sd9, 16'sh0041, 16'h5555, 24'hAAAAAA,
                        1'b1}};
    dir_table[3]  = '{'{-16'sd1, 16'sh0001, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000,
                        16'sh0000, 16'sh0000, 7'd1, 16'hAAAA, 24'h555555}, 1'b1,
                      '{-16'sd1, 16'sh0001, 16'sh0000, 16'sh0000, 16'hAAAA, 24'h555555,
                        1'b1}};
    dir_table[4]  = '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                        16'sh7FFF, 16'sh7FFF, 7'd64, 16'h1234, 24'h123456}, 1'b0,
                      '{default: '0}};
    dir_table[5]  = '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                        16'sh8000, 16'sh8000, 7'd64, 16'hFFFF, 24'h000000}, 1'b0,
                      '{default: '0}};
    // Counts above the limit saturate.
    dir_table[6]  = '{'{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                        16'sh7FFF, 16'sh8000, 7'd127, 16'h0001, 24'hFF0000}, 1'b0,
                      '{default: '0}};
    dir_table[7]  = '{'{16'sh0000, 16'sh0000, 16'sh4000, -16'sd16384, -16'sd100, 16'sh0064,
                        16'sh0010, -16'sd16, 7'd65, 16'h8000, 24'h00FF00}, 1'b0,
                      '{default: '0}};
    // Negative points must truncate toward zero.
    dir_table[8]  = '{'{-16'sd1, -16'sd1, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                        16'sh0000, 16'sh0000, 7'd3, 16'h0000, 24'h0000FF}, 1'b0,
                      '{default: '0}};
    dir_table[9]  = '{'{-16'sd5, 16'sh0003, -16'sd2, -16'sd8, 16'sh0001, -16'sd1,
                        -16'sd4, 16'sh0007, 7'd7, 16'h00FF, 24'h808080}, 1'b0,
                      '{default: '0}};
    dir_table[10] = '{'{16'sh0000, 16'sh0000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                        16'sh0000, 16'sh0000, 7'd2, 16'hAAAA, 24'h555555}, 1'b0,
                      '{default: '0}};
    dir_table[11] = '{'{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                        16'sh7FFF, 16'sh7FFF, 7'd5, 16'h5555, 24'hAAAAAA}, 1'b0,
                      '{default: '0}};
    dir_table[12] = '{'{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                        16'sh7FFF, 16'sh8000, 7'd64, 16'hFFFF, 24'hFFFFFF}, 1'b0,
                      '{default: '0}};
    dir_table[13] = '{'{16'sh1000, -16'sd4096, -16'sd12345, 16'sh2710, 16'sh0BAD, -16'sd1,
                        16'sh0FFF, 16'sh7000, 7'd33, 16'hC3A5, 24'h3C5AA5}, 1'b0,
                      '{default: '0}};
    dir_table[14] = '{'{-16'sd3, 16'sh0002, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                        16'sh0001, -16'sd1, 7'd100, 16'h0F0F, 24'hF0F0F0}, 1'b0,
                      '{default: '0}};
    dir_table[15] = '{'{16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001,
                        16'sh0001, 16'sh0001, 7'd2, 16'h7FFF, 24'h7FFFFF}, 1'b0,
                      '{default: '0}};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIR_ROWS; k++) begin
      send_curve(dir_table[k], 1'b0);
    end

    no_idle = 1'b0;
    for (int k = 0; k < RAND_CURVES; k++) begin
      if (k % 25 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (k == RAND_CURVES / 2) begin
        if (start) begin
          start <= 1'b0;
        end
        while (pending_segments.size() != 0) @(posedge clk);
      end
      r.curve.c0_x = rand_coord();
      r.curve.c0_y = rand_coord();
      r.curve.c1_x = rand_coord();
      r.curve.c1_y = rand_coord();
      r.curve.c2_x = rand_coord();
      r.curve.c2_y = rand_coord();
      r.curve.c3_x = rand_coord();
      r.curve.c3_y = rand_coord();
      case ($urandom_range(0, 19))
        0: r.curve.seg_count = COUNT_W'($urandom_range(65, 127));
        1, 2, 3: r.curve.seg_count = COUNT_W'($urandom_range(9, 64));
        default: r.curve.seg_count = COUNT_W'($urandom_range(0, 8));
      endcase
      r.curve.lwidth = LWIDTH_W'($urandom);
      r.curve.color  = COLOR_W'($urandom);
      r.typed        = 1'b0;
      r.want         = '{default: '0};
      send_curve(r, no_idle);
    end

    if (start) begin
      start <= 1'b0;
    end
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
design/cbf_pkg.sv
design/cbf_mul.sv
design/cbf_div.sv
design/cubic_bezier_flattener_core.sv
verif/tb_cubic_bezier_flattener_core.sv
